// ----- hdl/ame_pkg.sv -----
// ----------------------------------------------------------------------------
// ame_pkg
// shared constants, codes, command/status types and arithmetic helpers
// ----------------------------------------------------------------------------
package ame_pkg;

    localparam int DELAY_DEPTH = 32768;
    localparam int DEPTH_W     = $clog2(DELAY_DEPTH);
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;
    localparam int PARAM_W     = 14;
    localparam int MIX_W       = 17;
    localparam int CFG_W       = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int UNITY       = 65536;
    localparam int MIX_SHIFT   = 16;
    localparam int PROD_W      = SAMPLE_BITS + MIX_W + 1;
    localparam int LEV_W       = 2 * PARAM_W;
    localparam int XL_W        = SAMPLE_BITS + LEV_W + 1;
    localparam int QM_W        = LEV_W + 1;
    localparam int NUM_W       = QM_W + FRAC_BITS;
    localparam int DIV_CNT_W   = $clog2(NUM_W);

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARAM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX   = 2'd2;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_ECHO,
        MODE_HOLD,
        MODE_CRUSH
    } mode_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PASS,
        ST_ECHO_RD,
        ST_ECHO_MUL,
        ST_ECHO_WR,
        ST_LEV,
        ST_XL,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_CRUSH_FIN,
        ST_WET,
        ST_DRY,
        ST_BLEND,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_PASS,
        OP_ECHO_RD,
        OP_ECHO_MUL,
        OP_ECHO_WR,
        OP_LEV,
        OP_XL,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_CRUSH_FIN,
        OP_WET,
        OP_DRY,
        OP_BLEND
    } op_t;

    typedef struct packed {
        op_t  op;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic  clr_done;
        logic  div_done;
        mode_t mode;
        logic  crush_bypass;
    } sts_t;

    // saturate to the sample range
    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [63:0] v);
        logic signed [63:0] smax;
        logic signed [63:0] smin;
        smax = (64'sd1 <<< FRAC_BITS) - 64'sd1;
        smin = -(64'sd1 <<< FRAC_BITS);
        if (v > smax) begin
            return SAMPLE_BITS'(smax);
        end
        if (v < smin) begin
            return SAMPLE_BITS'(smin);
        end
        return SAMPLE_BITS'(v);
    endfunction

    // divide by unity, round to nearest, halves away from zero
    function automatic logic signed [63:0] round_unity(input logic signed [63:0] n);
        logic [63:0] m;
        logic [63:0] q;
        m = (n < 0) ? 64'(-n) : 64'(n);
        q = (m + 64'(UNITY / 2)) >> MIX_SHIFT;
        return (n < 0) ? -$signed(q) : $signed(q);
    endfunction

endpackage

// ----- hdl/ame_ctrl.sv -----
// ----------------------------------------------------------------------------
// ame_ctrl
// sequencing state machine: store clear, per-mode step order, output beat
// ----------------------------------------------------------------------------
module ame_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  ame_pkg::sts_t sts,
    output ame_pkg::cmd_t cmd
);

    ame_pkg::state_t state_reg;
    ame_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ame_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = ame_pkg::OP_NONE;
        cmd.load_out   = 1'b0;
        in_ready       = 1'b0;
        case (state_reg)
            ame_pkg::ST_CLEAR:
            begin
                cmd.op = ame_pkg::OP_CLEAR;
                if (sts.clr_done)
                begin
                    state_next = ame_pkg::ST_IDLE;
                end
            end
            ame_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = ame_pkg::OP_ACCEPT;
                    case (sts.mode)
                        ame_pkg::MODE_ECHO:  state_next = ame_pkg::ST_ECHO_RD;
                        ame_pkg::MODE_HOLD:  state_next = ame_pkg::ST_WET;
                        ame_pkg::MODE_CRUSH: state_next = sts.crush_bypass ?
                                                 ame_pkg::ST_WET : ame_pkg::ST_LEV;
                        default:             state_next = ame_pkg::ST_PASS;
                    endcase
                end
            end
            ame_pkg::ST_PASS:
            begin
                cmd.op     = ame_pkg::OP_PASS;
                state_next = ame_pkg::ST_FINISH;
            end
            ame_pkg::ST_ECHO_RD:
            begin
                cmd.op     = ame_pkg::OP_ECHO_RD;
                state_next = ame_pkg::ST_ECHO_MUL;
            end
            ame_pkg::ST_ECHO_MUL:
            begin
                cmd.op     = ame_pkg::OP_ECHO_MUL;
                state_next = ame_pkg::ST_ECHO_WR;
            end
            ame_pkg::ST_ECHO_WR:
            begin
                cmd.op     = ame_pkg::OP_ECHO_WR;
                state_next = ame_pkg::ST_FINISH;
            end
            ame_pkg::ST_LEV:
            begin
                cmd.op     = ame_pkg::OP_LEV;
                state_next = ame_pkg::ST_XL;
            end
            ame_pkg::ST_XL:
            begin
                cmd.op     = ame_pkg::OP_XL;
                state_next = ame_pkg::ST_DIV_LOAD;
            end
            ame_pkg::ST_DIV_LOAD:
            begin
                cmd.op     = ame_pkg::OP_DIV_LOAD;
                state_next = ame_pkg::ST_DIV_STEP;
            end
            ame_pkg::ST_DIV_STEP:
            begin
                cmd.op = ame_pkg::OP_DIV_STEP;
                if (sts.div_done)
                begin
                    state_next = ame_pkg::ST_CRUSH_FIN;
                end
            end
            ame_pkg::ST_CRUSH_FIN:
            begin
                cmd.op     = ame_pkg::OP_CRUSH_FIN;
                state_next = ame_pkg::ST_WET;
            end
            ame_pkg::ST_WET:
            begin
                cmd.op     = ame_pkg::OP_WET;
                state_next = ame_pkg::ST_DRY;
            end
            ame_pkg::ST_DRY:
            begin
                cmd.op     = ame_pkg::OP_DRY;
                state_next = ame_pkg::ST_BLEND;
            end
            ame_pkg::ST_BLEND:
            begin
                cmd.op     = ame_pkg::OP_BLEND;
                state_next = ame_pkg::ST_FINISH;
            end
            ame_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ame_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ame_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hdl/ame_datapath.sv -----
// ----------------------------------------------------------------------------
// ame_datapath
// delay store, channel/phase tracking, multiplies, bitcrush divider, output
// ----------------------------------------------------------------------------
module ame_datapath (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  ame_pkg::cmd_t                            cmd,
    output ame_pkg::sts_t                            sts,
    input  logic [1:0]                               effect_mode,
    input  logic [ame_pkg::PARAM_W-1:0]              effect_param,
    input  logic [ame_pkg::MIX_W-1:0]                mix_ratio,
    input  logic signed [ame_pkg::SAMPLE_BITS-1:0]   sample_in,
    input  logic                                     block_start,
    output logic signed [ame_pkg::SAMPLE_BITS-1:0]   sample_out
);

    localparam int SB = ame_pkg::SAMPLE_BITS;
    localparam int AW = ame_pkg::DEPTH_W;
    localparam int MIX_W_L = ame_pkg::MIX_W;

    logic signed [SB-1:0]                 mem [ame_pkg::DELAY_DEPTH];

    logic [AW-1:0]                        clr_idx_reg;
    logic [AW-1:0]                        pos_reg;
    logic                                 ch_reg;
    logic [ame_pkg::PARAM_W-1:0]          phase_reg;
    logic signed [SB-1:0]                 held_reg [2];

    logic signed [SB-1:0]                 x_reg;
    logic signed [SB-1:0]                 wet_reg;
    logic signed [SB-1:0]                 rd_data_reg;
    logic signed [SB-1:0]                 res_reg;
    logic signed [SB-1:0]                 out_reg;
    logic signed [ame_pkg::PROD_W-1:0]    prod_reg;
    logic signed [ame_pkg::PROD_W-1:0]    acc_reg;
    logic [ame_pkg::LEV_W-1:0]            lev_reg;
    logic signed [ame_pkg::XL_W-1:0]      xl_reg;
    logic                                 qneg_reg;
    logic [ame_pkg::LEV_W-1:0]            rem_reg;
    logic [ame_pkg::NUM_W-1:0]            num_reg;
    logic [ame_pkg::DIV_CNT_W-1:0]        div_cnt_reg;

    logic [MIX_W_L-1:0]                   mix_eff;
    logic [ame_pkg::PARAM_W-1:0]          interval;
    logic                                 ch_now;
    logic [ame_pkg::PARAM_W-1:0]          ph_now;
    logic [ame_pkg::PARAM_W-1:0]          ph_inc;
    logic signed [SB-1:0]                 held_new;

    logic                                 mem_we;
    logic [AW-1:0]                        mem_wa;
    logic signed [SB-1:0]                 mem_wd;
    logic signed [SB-1:0]                 echo_res;
    logic signed [SB-1:0]                 blend_res;
    logic [AW-1:0]                        echo_wa;

    logic [ame_pkg::XL_W-1:0]             xl_mag;
    logic [ame_pkg::QM_W-1:0]             qm;
    logic [ame_pkg::LEV_W:0]              shifted;
    logic                                 ge;
    logic signed [SB-1:0]                 crush_val;
    logic signed [SB:0]                   crush_neg;

    assign mix_eff  = (mix_ratio > MIX_W_L'(ame_pkg::UNITY)) ?
                      MIX_W_L'(ame_pkg::UNITY) : mix_ratio;
    assign interval = (effect_param == '0) ? ame_pkg::PARAM_W'(1) : effect_param;

    // channel and frame phase as seen by the incoming sample
    assign ch_now   = block_start ? 1'b0 : ch_reg;
    assign ph_now   = (block_start || (phase_reg >= interval)) ? '0 : phase_reg;
    assign ph_inc   = ph_now + ame_pkg::PARAM_W'(1);
    assign held_new = (ph_now == '0) ? sample_in : held_reg[ch_now];

    assign echo_res = ame_pkg::sat_sample(64'(x_reg) +
                                          ame_pkg::round_unity(64'(prod_reg)));
    assign blend_res = ame_pkg::sat_sample(ame_pkg::round_unity(64'(acc_reg) +
                                                                64'(prod_reg)));
    assign echo_wa  = pos_reg + AW'(32'(effect_param) << 1);

    assign mem_we = (cmd.op == ame_pkg::OP_CLEAR) || (cmd.op == ame_pkg::OP_ECHO_WR);
    assign mem_wa = (cmd.op == ame_pkg::OP_CLEAR) ? clr_idx_reg : echo_wa;
    assign mem_wd = (cmd.op == ame_pkg::OP_CLEAR) ? '0 : echo_res;

    // ceiling of x*levels over 2^frac, kept as sign and magnitude
    assign xl_mag = (xl_reg < 0) ? ame_pkg::XL_W'(-xl_reg) : ame_pkg::XL_W'(xl_reg);
    assign qm     = (xl_reg < 0) ?
                    ame_pkg::QM_W'(xl_mag >> ame_pkg::FRAC_BITS) :
                    ame_pkg::QM_W'((xl_mag + ame_pkg::XL_W'((1 << ame_pkg::FRAC_BITS) - 1))
                                   >> ame_pkg::FRAC_BITS);

    assign shifted = {rem_reg, num_reg[ame_pkg::NUM_W-1]};
    assign ge      = shifted >= {1'b0, lev_reg};

    assign crush_neg = -$signed({1'b0, num_reg[SB-1:0]});
    always_comb
    begin
        if (!qneg_reg)
        begin
            crush_val = (num_reg > ame_pkg::NUM_W'((1 << ame_pkg::FRAC_BITS) - 1)) ?
                        SB'((1 << ame_pkg::FRAC_BITS) - 1) : SB'(num_reg);
        end
        else
        begin
            crush_val = (num_reg > ame_pkg::NUM_W'(1 << ame_pkg::FRAC_BITS)) ?
                        SB'(-(1 << ame_pkg::FRAC_BITS)) : crush_neg[SB-1:0];
        end
    end

    // delay store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.op == ame_pkg::OP_ECHO_RD)
        begin
            rd_data_reg <= mem[pos_reg];
        end
    end

    // tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            pos_reg     <= '0;
            ch_reg      <= 1'b0;
            phase_reg   <= '0;
            held_reg[0] <= '0;
            held_reg[1] <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.op == ame_pkg::OP_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
            end
            if (cmd.op == ame_pkg::OP_ACCEPT)
            begin
                held_reg[ch_now] <= held_new;
                ch_reg           <= ~ch_now;
                if (ch_now)
                begin
                    phase_reg <= (ph_inc >= interval) ? '0 : ph_inc;
                end
                else
                begin
                    phase_reg <= ph_now;
                end
            end
            if (cmd.op == ame_pkg::OP_ECHO_WR)
            begin
                pos_reg <= pos_reg + AW'(1);
            end
            if (cmd.op == ame_pkg::OP_DIV_LOAD)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.op == ame_pkg::OP_DIV_STEP)
            begin
                div_cnt_reg <= div_cnt_reg + ame_pkg::DIV_CNT_W'(1);
            end
        end
    end

    // arithmetic payload
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            ame_pkg::OP_ACCEPT:
            begin
                x_reg   <= sample_in;
                wet_reg <= (ame_pkg::mode_t'(effect_mode) == ame_pkg::MODE_HOLD) ?
                           held_new : sample_in;
            end
            ame_pkg::OP_PASS:
            begin
                res_reg <= x_reg;
            end
            ame_pkg::OP_ECHO_MUL:
            begin
                prod_reg <= rd_data_reg * $signed({1'b0, mix_eff});
            end
            ame_pkg::OP_ECHO_WR:
            begin
                res_reg <= echo_res;
            end
            ame_pkg::OP_LEV:
            begin
                lev_reg <= ame_pkg::LEV_W'(ame_pkg::LEV_W'(effect_param) *
                                           ame_pkg::LEV_W'(effect_param))
                           - ame_pkg::LEV_W'(1);
            end
            ame_pkg::OP_XL:
            begin
                xl_reg <= x_reg * $signed({1'b0, lev_reg});
            end
            ame_pkg::OP_DIV_LOAD:
            begin
                qneg_reg <= xl_reg < 0;
                rem_reg  <= '0;
                num_reg  <= (ame_pkg::NUM_W'(qm) << ame_pkg::FRAC_BITS) +
                            ame_pkg::NUM_W'(lev_reg >> 1);
            end
            ame_pkg::OP_DIV_STEP:
            begin
                rem_reg <= ge ? ame_pkg::LEV_W'(shifted - {1'b0, lev_reg}) :
                                shifted[ame_pkg::LEV_W-1:0];
                num_reg <= {num_reg[ame_pkg::NUM_W-2:0], ge};
            end
            ame_pkg::OP_CRUSH_FIN:
            begin
                wet_reg <= crush_val;
            end
            ame_pkg::OP_WET:
            begin
                acc_reg <= wet_reg * $signed({1'b0, mix_eff});
            end
            ame_pkg::OP_DRY:
            begin
                prod_reg <= x_reg * $signed({1'b0, MIX_W_L'(ame_pkg::UNITY) - mix_eff});
            end
            ame_pkg::OP_BLEND:
            begin
                res_reg <= blend_res;
            end
            default:
            begin
            end
        endcase
        if (cmd.load_out)
        begin
            out_reg <= res_reg;
        end
    end

    assign sts.clr_done     = (clr_idx_reg == '1);
    assign sts.div_done     = (div_cnt_reg == ame_pkg::DIV_CNT_W'(ame_pkg::NUM_W - 1));
    assign sts.mode         = ame_pkg::mode_t'(effect_mode);
    assign sts.crush_bypass = (effect_param < ame_pkg::PARAM_W'(2));
    assign sample_out       = out_reg;

endmodule

// ----- hdl/audio_multi_effect_unit_core.sv -----
// ----------------------------------------------------------------------------
// audio_multi_effect_unit_core
// stereo multi-effect: passthrough, feedback echo, sample-and-hold, bitcrush
// ----------------------------------------------------------------------------
// channel   | handshake           | payload
// ----------+---------------------+------------------------------------------
// config    | cfg_we              | cfg_index, cfg_data
// input     | in_valid / in_ready | sample_in, block_start
// output    | out_valid/out_ready | sample_out
//
// every beat is taken in the idle state; bitcrush with depth value two or
// more also runs the 52-step restoring divider, which passthrough, echo,
// sample-and-hold and bitcrush with depth value below two skip
// reset: a clearing pass writes zero to all 32768 delay entries, one per
// cycle, with in_ready low; config writes are taken meanwhile
// stalls: a finished result waits in the output register while the next
// input beat is taken; a second result waits until that one leaves
module audio_multi_effect_unit_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [ame_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [ame_pkg::CFG_W-1:0]              cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [ame_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                                   block_start,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [ame_pkg::SAMPLE_BITS-1:0] sample_out
);

    // config registers
    logic [1:0]                  effect_mode_reg;
    logic [ame_pkg::PARAM_W-1:0] effect_param_reg;
    logic [ame_pkg::MIX_W-1:0]   mix_ratio_reg;

    // controller to datapath
    ame_pkg::cmd_t cmd;
    ame_pkg::sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            effect_mode_reg  <= 2'd0;
            effect_param_reg <= ame_pkg::PARAM_W'(1);
            mix_ratio_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ame_pkg::CFG_MODE:  effect_mode_reg  <= cfg_data[1:0];
                ame_pkg::CFG_PARAM: effect_param_reg <= cfg_data[ame_pkg::PARAM_W-1:0];
                ame_pkg::CFG_MIX:   mix_ratio_reg    <= cfg_data[ame_pkg::MIX_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // sequencing
    ame_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // store, tracking and arithmetic
    ame_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .effect_mode  (effect_mode_reg),
        .effect_param (effect_param_reg),
        .mix_ratio    (mix_ratio_reg),
        .sample_in    (sample_in),
        .block_start  (block_start),
        .sample_out   (sample_out)
    );

endmodule

// ----- hdl/ame_checker.sv -----
// ----------------------------------------------------------------------------
// ame_checker
// port-level checks on the effect unit, bound to the top level
// ----------------------------------------------------------------------------
module ame_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_ready,
    input logic                                   out_valid,
    input logic                                   out_ready,
    input logic signed [ame_pkg::SAMPLE_BITS-1:0] sample_out
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out))
        else $error("stalled output beat changed");

    // one beat in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // a result is presented only from the working phase
    a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without work");

endmodule

bind audio_multi_effect_unit_core ame_checker u_ame_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
);
